/* hdl/nearest_two_polylines_to_point_core_assert.svh */
// Assertion macros shared by the core's checks
`ifndef NEAREST_TWO_POLYLINES_TO_POINT_CORE_ASSERT_SVH
`define NEAREST_TWO_POLYLINES_TO_POINT_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset
`define NTP_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define NTP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* hdl/ntp_pkg.sv */
package ntp_pkg;

   localparam int CoordBits  = 23;
   localparam int DiffBits   = CoordBits + 1;
   localparam int SqBits     = 2 * DiffBits;
   localparam int RoadBits   = 10;
   localparam int MaxRoads   = 1024;
   localparam int DistBits   = 24;
   localparam int RootBits   = SqBits / 2;
   localparam int RemBits    = RootBits + 2;
   localparam int QueueDepth = 4;
   localparam int QAddrBits  = $clog2(QueueDepth);
   localparam int QCntBits   = $clog2(QueueDepth + 1);
   localparam int BitIdxBits = $clog2(SqBits);
   localparam int RootIdxBits = $clog2(RootBits);

   // One classified segment waiting for the back end
   typedef struct packed {
      logic [SqBits-1:0]   base;
      logic [SqBits-1:0]   c1;
      logic [SqBits-1:0]   c2;
      logic                interior;
      logic [RoadBits-1:0] road;
      logic                road_done;
      logic                query_done;
   } ntp_item_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic [QCntBits-1:0] count;
      logic                empty;
   } ntp_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_FOLD,
      ST_SQRT,
      ST_DONE
   } ntp_state_type;

endpackage

/* hdl/ntp_front.sv */
module ntp_front
   import ntp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [CoordBits-1:0] query_x,
   input  logic signed [CoordBits-1:0] query_y,
   input  logic signed [CoordBits-1:0] start_x,
   input  logic signed [CoordBits-1:0] start_y,
   input  logic signed [CoordBits-1:0] end_x,
   input  logic signed [CoordBits-1:0] end_y,
   input  logic [RoadBits-1:0]         road_index,
   input  logic                        road_done,
   input  logic                        query_done,
   input  ntp_qstat_type               qstat,
   output logic                        push,
   output ntp_item_type                item
);

   logic signed [DiffBits-1:0] wx_ff, wy_ff, vx_ff, vy_ff, ux_ff, uy_ff;
   logic [RoadBits-1:0]        road1_ff, road2_ff;
   logic                       rd1_ff, rd2_ff, qd1_ff, qd2_ff;
   logic                       s1_valid_ff, s2_valid_ff;
   logic signed [SqBits-1:0]   pvx_ff, pvy_ff, pwx_ff, pwy_ff;
   logic signed [SqBits-1:0]   pcx_ff, pcy_ff, pux_ff, puy_ff;
   logic signed [SqBits:0]     c1;
   logic [SqBits-1:0]          w2, c2, u2;
   logic [QCntBits:0]          occupancy;
   logic                       accept;

   // Hold back when queue plus in-flight items would overrun it
   assign occupancy = (QCntBits+1)'(qstat.count) + (QCntBits+1)'(s1_valid_ff)
                    + (QCntBits+1)'(s2_valid_ff);
   assign in_ready  = occupancy < (QCntBits+1)'(QueueDepth);
   assign accept    = in_valid && in_ready;

   // Valid bits of the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage one: differences
   always_ff @(posedge clock) begin
      if (accept) begin
         wx_ff    <= DiffBits'(query_x) - DiffBits'(start_x);
         wy_ff    <= DiffBits'(query_y) - DiffBits'(start_y);
         vx_ff    <= DiffBits'(end_x) - DiffBits'(start_x);
         vy_ff    <= DiffBits'(end_y) - DiffBits'(start_y);
         ux_ff    <= DiffBits'(query_x) - DiffBits'(end_x);
         uy_ff    <= DiffBits'(query_y) - DiffBits'(end_y);
         road1_ff <= RoadBits'(road_index % MaxRoads);
         rd1_ff   <= road_done;
         qd1_ff   <= query_done;
      end
   end

   // Stage two: products
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         pvx_ff   <= wx_ff * vx_ff;
         pvy_ff   <= wy_ff * vy_ff;
         pwx_ff   <= wx_ff * wx_ff;
         pwy_ff   <= wy_ff * wy_ff;
         pcx_ff   <= vx_ff * vx_ff;
         pcy_ff   <= vy_ff * vy_ff;
         pux_ff   <= ux_ff * ux_ff;
         puy_ff   <= uy_ff * uy_ff;
         road2_ff <= road1_ff;
         rd2_ff   <= rd1_ff;
         qd2_ff   <= qd1_ff;
      end
   end

   // Sum the products and classify where the projection falls
   always_comb begin
      c1 = (SqBits+1)'(pvx_ff) + (SqBits+1)'(pvy_ff);
      w2 = $unsigned(pwx_ff) + $unsigned(pwy_ff);
      c2 = $unsigned(pcx_ff) + $unsigned(pcy_ff);
      u2 = $unsigned(pux_ff) + $unsigned(puy_ff);
      item.c1         = c1[SqBits-1:0];
      item.c2         = c2;
      item.road       = road2_ff;
      item.road_done  = rd2_ff;
      item.query_done = qd2_ff;
      priority if (c1 <= 0) begin
         item.base     = w2;
         item.interior = 1'b0;
      end else if ($signed({1'b0, c2}) <= c1) begin
         item.base     = u2;
         item.interior = 1'b0;
      end else begin
         item.base     = w2;
         item.interior = 1'b1;
      end
   end

   assign push = s2_valid_ff;

endmodule

/* hdl/ntp_fifo.sv */
module ntp_fifo
   import ntp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ntp_item_type  push_item,
   input  logic          pop,
   output ntp_item_type  head,
   output ntp_qstat_type qstat
);

   ntp_item_type          slot_ff [QueueDepth];
   logic [QAddrBits-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCntBits-1:0]   count_ff;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QAddrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QAddrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCntBits'(push) - QCntBits'(pop);
      end
   end

   // Store the incoming request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = (count_ff == '0);

endmodule

/* hdl/ntp_back.sv */
module ntp_back
   import ntp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ntp_item_type        head,
   input  ntp_qstat_type       qstat,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [RoadBits-1:0] nearest_road,
   output logic [RoadBits-1:0] second_road,
   output logic [DistBits-1:0] nearest_distance,
   output logic [DistBits-1:0] second_distance,
   output logic                found_nearest,
   output logic                found_second
);

   localparam logic [SqBits-1:0] SqAllOnes = '1;

   ntp_state_type           state_ff, state_in;
   ntp_item_type            cur_ff, cur_in;
   logic [SqBits-1:0]       q_ff, q_in, r_ff, r_in;
   logic [BitIdxBits-1:0]   bit_ff, bit_in;
   logic                    phase_ff, phase_in;
   logic [SqBits-1:0]       road_min_ff, road_min_in;
   logic [SqBits-1:0]       best_sq_ff, best_sq_in, runner_sq_ff, runner_sq_in;
   logic [RoadBits-1:0]     best_road_ff, best_road_in, runner_road_ff, runner_road_in;
   logic                    best_valid_ff, best_valid_in, runner_valid_ff, runner_valid_in;
   logic [SqBits-1:0]       n0_ff, n0_in, n1_ff, n1_in;
   logic [RootBits-1:0]     root0_ff, root0_in, root1_ff, root1_in;
   logic [RemBits-1:0]      rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [RootIdxBits-1:0]  sq_cnt_ff, sq_cnt_in;
   logic                    out_valid_ff, out_valid_in;
   logic [RoadBits-1:0]     o_near_road_ff, o_near_road_in, o_sec_road_ff, o_sec_road_in;
   logic [DistBits-1:0]     o_near_dist_ff, o_near_dist_in, o_sec_dist_ff, o_sec_dist_in;
   logic                    o_found0_ff, o_found0_in, o_found1_ff, o_found1_in;
   logic [SqBits:0]         r_wide;
   logic [SqBits-1:0]       dist_sq;
   logic [RemBits+1:0]      sq_t0, sq_t1, trial0, trial1;

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         road_min_ff     <= SqAllOnes;
         best_sq_ff      <= SqAllOnes;
         runner_sq_ff    <= SqAllOnes;
         best_road_ff    <= '0;
         runner_road_ff  <= '0;
         best_valid_ff   <= 1'b0;
         runner_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         road_min_ff     <= road_min_in;
         best_sq_ff      <= best_sq_in;
         runner_sq_ff    <= runner_sq_in;
         best_road_ff    <= best_road_in;
         runner_road_ff  <= runner_road_in;
         best_valid_ff   <= best_valid_in;
         runner_valid_ff <= runner_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      q_ff           <= q_in;
      r_ff           <= r_in;
      bit_ff         <= bit_in;
      phase_ff       <= phase_in;
      n0_ff          <= n0_in;
      n1_ff          <= n1_in;
      root0_ff       <= root0_in;
      root1_ff       <= root1_in;
      rem0_ff        <= rem0_in;
      rem1_ff        <= rem1_in;
      sq_cnt_ff      <= sq_cnt_in;
      o_near_road_ff <= o_near_road_in;
      o_sec_road_ff  <= o_sec_road_in;
      o_near_dist_ff <= o_near_dist_in;
      o_sec_dist_ff  <= o_sec_dist_in;
      o_found0_ff    <= o_found0_in;
      o_found1_ff    <= o_found1_in;
   end

   // Sequencer: divide, track minimum, fold roads, take square roots
   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      bit_in          = bit_ff;
      phase_in        = phase_ff;
      road_min_in     = road_min_ff;
      best_sq_in      = best_sq_ff;
      runner_sq_in    = runner_sq_ff;
      best_road_in    = best_road_ff;
      runner_road_in  = runner_road_ff;
      best_valid_in   = best_valid_ff;
      runner_valid_in = runner_valid_ff;
      n0_in           = n0_ff;
      n1_in           = n1_ff;
      root0_in        = root0_ff;
      root1_in        = root1_ff;
      rem0_in         = rem0_ff;
      rem1_in         = rem1_ff;
      sq_cnt_in       = sq_cnt_ff;
      out_valid_in    = out_valid_ff && !out_ready;
      o_near_road_in  = o_near_road_ff;
      o_sec_road_in   = o_sec_road_ff;
      o_near_dist_in  = o_near_dist_ff;
      o_sec_dist_in   = o_sec_dist_ff;
      o_found0_in     = o_found0_ff;
      o_found1_in     = o_found1_ff;
      pop             = 1'b0;
      r_wide          = '0;
      dist_sq         = cur_ff.interior ? cur_ff.base - q_ff : cur_ff.base;
      sq_t0           = {rem0_ff, n0_ff[SqBits-1 -: 2]};
      sq_t1           = {rem1_ff, n1_ff[SqBits-1 -: 2]};
      trial0          = (RemBits+2)'({root0_ff, 2'b01});
      trial1          = (RemBits+2)'({root1_ff, 2'b01});

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               cur_in   = head;
               q_in     = '0;
               r_in     = '0;
               bit_in   = BitIdxBits'(SqBits - 1);
               phase_in = 1'b0;
               state_in = head.interior ? ST_DIV : ST_UPDATE;
            end
         end
         ST_DIV: begin
            // floor(c1*c1/c2): shift-and-add multiply folded into long division
            if (!phase_ff) begin
               r_wide = {r_ff, 1'b0};
               q_in   = {q_ff[SqBits-2:0], 1'b0};
               if (r_wide >= (SqBits+1)'(cur_ff.c2)) begin
                  r_wide  = r_wide - (SqBits+1)'(cur_ff.c2);
                  q_in[0] = 1'b1;
               end
               r_in     = r_wide[SqBits-1:0];
               phase_in = 1'b1;
            end else begin
               r_wide = (SqBits+1)'(r_ff);
               if (cur_ff.c1[bit_ff]) begin
                  r_wide = r_wide + (SqBits+1)'(cur_ff.c1);
                  if (r_wide >= (SqBits+1)'(cur_ff.c2)) begin
                     r_wide = r_wide - (SqBits+1)'(cur_ff.c2);
                     q_in   = q_ff + 1'b1;
                  end
               end
               r_in     = r_wide[SqBits-1:0];
               phase_in = 1'b0;
               bit_in   = bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (dist_sq < road_min_ff) begin
               road_min_in = dist_sq;
            end
            state_in = (cur_ff.road_done || cur_ff.query_done) ? ST_FOLD : ST_IDLE;
         end
         ST_FOLD: begin
            // Strict compare keeps the earlier road on a tie
            priority if (!best_valid_ff || road_min_ff < best_sq_ff) begin
               runner_sq_in    = best_sq_ff;
               runner_road_in  = best_road_ff;
               runner_valid_in = best_valid_ff;
               best_sq_in      = road_min_ff;
               best_road_in    = cur_ff.road;
               best_valid_in   = 1'b1;
            end else if (!runner_valid_ff || road_min_ff < runner_sq_ff) begin
               runner_sq_in    = road_min_ff;
               runner_road_in  = cur_ff.road;
               runner_valid_in = 1'b1;
            end else begin
               runner_valid_in = runner_valid_ff;
            end
            road_min_in = SqAllOnes;
            n0_in       = best_sq_in;
            n1_in       = runner_sq_in;
            root0_in    = '0;
            root1_in    = '0;
            rem0_in     = '0;
            rem1_in     = '0;
            sq_cnt_in   = RootIdxBits'(RootBits - 1);
            state_in    = cur_ff.query_done ? ST_SQRT : ST_IDLE;
         end
         ST_SQRT: begin
            // One result bit per cycle for both distances
            if (sq_t0 >= trial0) begin
               rem0_in  = RemBits'(sq_t0 - trial0);
               root0_in = {root0_ff[RootBits-2:0], 1'b1};
            end else begin
               rem0_in  = RemBits'(sq_t0);
               root0_in = {root0_ff[RootBits-2:0], 1'b0};
            end
            if (sq_t1 >= trial1) begin
               rem1_in  = RemBits'(sq_t1 - trial1);
               root1_in = {root1_ff[RootBits-2:0], 1'b1};
            end else begin
               rem1_in  = RemBits'(sq_t1);
               root1_in = {root1_ff[RootBits-2:0], 1'b0};
            end
            n0_in     = {n0_ff[SqBits-3:0], 2'b00};
            n1_in     = {n1_ff[SqBits-3:0], 2'b00};
            sq_cnt_in = sq_cnt_ff - 1'b1;
            if (sq_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the result register once it is free, then clear
            if (!out_valid_ff || out_ready) begin
               out_valid_in    = 1'b1;
               o_near_road_in  = best_valid_ff ? best_road_ff : '0;
               o_sec_road_in   = runner_valid_ff ? runner_road_ff : '0;
               o_near_dist_in  = best_valid_ff ? DistBits'(root0_ff) : '0;
               o_sec_dist_in   = runner_valid_ff ? DistBits'(root1_ff) : '0;
               o_found0_in     = best_valid_ff;
               o_found1_in     = runner_valid_ff;
               road_min_in     = SqAllOnes;
               best_sq_in      = SqAllOnes;
               runner_sq_in    = SqAllOnes;
               best_road_in    = '0;
               runner_road_in  = '0;
               best_valid_in   = 1'b0;
               runner_valid_in = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid        = out_valid_ff;
   assign nearest_road     = o_near_road_ff;
   assign second_road      = o_sec_road_ff;
   assign nearest_distance = o_near_dist_ff;
   assign second_distance  = o_sec_dist_ff;
   assign found_nearest    = o_found0_ff;
   assign found_second     = o_found1_ff;

endmodule

/* hdl/nearest_two_polylines_to_point_core.sv */
// Nearest two roads to a query point. Each request is one road segment with
// the query point; tlast closes the query and yields one response with both
// road indices, Q16.8 distances and found flags. The front end computes the
// distance terms in a two-stage multiplier pipeline and queues up to four
// classified segments. The back end takes them one at a time: IDLE pops a
// segment and UPDATE tracks the road minimum; an interior projection first
// runs the 48-bit shared divide in DIV, a road close adds FOLD, and query end
// adds the square roots in SQRT before DONE. The back end takes no new
// segment until done with the last, so its divider chiefly sets the rate.
`include "nearest_two_polylines_to_point_core_assert.svh"

module nearest_two_polylines_to_point_core
   import ntp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // query_x, query_y, start_x, start_y, end_x, end_y, road_index, zero pad
   input  logic [151:0] req_tdata,
   // road_done
   input  logic [0:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // nearest_road, second_road, nearest_distance, second_distance, zero pad
   output logic [71:0]  rsp_tdata,
   // found_nearest, found_second
   output logic [1:0]   rsp_tuser
);

   ntp_item_type        push_item, head;
   ntp_qstat_type       qstat;
   logic                push, pop;
   logic [RoadBits-1:0] nearest_road, second_road;
   logic [DistBits-1:0] nearest_distance, second_distance;
   logic                found_nearest, found_second;

   ntp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .query_x    (req_tdata[22:0]),
      .query_y    (req_tdata[45:23]),
      .start_x    (req_tdata[68:46]),
      .start_y    (req_tdata[91:69]),
      .end_x      (req_tdata[114:92]),
      .end_y      (req_tdata[137:115]),
      .road_index (req_tdata[147:138]),
      .road_done  (req_tuser[0]),
      .query_done (req_tlast),
      .qstat      (qstat),
      .push       (push),
      .item       (push_item)
   );

   ntp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   ntp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .qstat            (qstat),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .nearest_road     (nearest_road),
      .second_road      (second_road),
      .nearest_distance (nearest_distance),
      .second_distance  (second_distance),
      .found_nearest    (found_nearest),
      .found_second     (found_second)
   );

   assign rsp_tdata = {4'b0000, second_distance, nearest_distance, second_road, nearest_road};
   assign rsp_tuser = {found_second, found_nearest};

   `NTP_ASSERT_NOW(a_second_needs_first, rsp_tvalid && found_second, found_nearest,
                   "second road reported without a nearest road")
   `NTP_ASSERT_NOW(a_order_kept, rsp_tvalid && found_second,
                   nearest_distance <= second_distance, "nearest road farther than second")
   `NTP_ASSERT_NOW(a_pop_nonempty, pop, !qstat.empty, "segment queue popped while empty")
   `NTP_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= QCntBits'(QueueDepth),
                   "segment queue overfilled")

endmodule
